FILE: sv/sst_pkg.sv
// shared types and constants for the string set table
// no dependencies; imported by every other file of the block
package sst_pkg;

   localparam int SST_SLOTS     = 16;
   localparam int SST_NUM_SETS  = 4;
   localparam int SST_KEY_BYTES = 30;

   // fixed field widths of the request and response beats
   localparam int KEY_WORD_W = 64;
   localparam int KEY_W3_W   = 48;
   localparam int KEY_W      = 3 * KEY_WORD_W + KEY_W3_W;
   localparam int SET_W      = 2;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 5;

   // one table entry: set tag above the key
   localparam int ENTRY_W = KEY_W + SET_W;

   localparam logic CMD_ADD    = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ADDED     = 3'd0,
      ST_PRESENT   = 3'd1,
      ST_REMOVED   = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

   typedef struct packed {
      logic hit_found;
      logic free_found;
   } scan_flags_type;

endpackage

FILE: sv/sst_if.sv
// request and response channels of the string set table
// depends on sst_pkg for field widths
interface sst_req_if import sst_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  cmd;
   logic [SET_W-1:0]      set_sel;
   logic [KEY_WORD_W-1:0] key_w0;
   logic [KEY_WORD_W-1:0] key_w1;
   logic [KEY_WORD_W-1:0] key_w2;
   logic [KEY_W3_W-1:0]   key_w3;

   modport source (output valid, cmd, set_sel, key_w0, key_w1, key_w2, key_w3,
                   input ready);
   modport sink   (input valid, cmd, set_sel, key_w0, key_w1, key_w2, key_w3,
                   output ready);
endinterface

interface sst_rsp_if import sst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  set_count;

   modport source (output valid, status, set_count, input ready);
   modport sink   (input valid, status, set_count, output ready);
endinterface

FILE: sv/sst_slot_mem.sv
// slot storage: set tag and key of every slot, one write and one read port
// depends on sst_pkg; read data is registered
module sst_slot_mem import sst_pkg::*; #(
   parameter  int SLOTS = SST_SLOTS,
   localparam int AW    = $clog2(SLOTS)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [ENTRY_W-1:0] wr_data,
   input  logic [AW-1:0]      rd_addr,
   output logic [ENTRY_W-1:0] rd_data
);

   logic [ENTRY_W-1:0] mem_ff [SLOTS];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/sst_scan.sv
// shared compare unit: checks one slot per cycle while cmp_en is high
// against the request key; keeps the first matching and first free slot
// depends on sst_pkg
module sst_scan import sst_pkg::*; #(
   parameter  int SLOTS = SST_SLOTS,
   localparam int AW    = $clog2(SLOTS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               cmp_en,
   input  logic [AW-1:0]      cmp_idx,
   input  logic               cmp_slot_valid,
   input  logic [ENTRY_W-1:0] cmp_entry,
   input  logic [KEY_W-1:0]   key,
   input  logic [SET_W-1:0]   set_sel,
   output scan_flags_type     flags,
   output logic [AW-1:0]      hit_idx,
   output logic [AW-1:0]      free_idx
);

   logic          hit_found_ff, hit_found_in;
   logic          free_found_ff, free_found_in;
   logic [AW-1:0] hit_idx_ff, hit_idx_in;
   logic [AW-1:0] free_idx_ff, free_idx_in;
   logic          match;

   assign match = cmp_slot_valid
                  && (cmp_entry[ENTRY_W-1 -: SET_W] == set_sel)
                  && (cmp_entry[KEY_W-1:0] == key);

   always_comb begin
      hit_found_in  = hit_found_ff;
      free_found_in = free_found_ff;
      hit_idx_in    = hit_idx_ff;
      free_idx_in   = free_idx_ff;
      if (start) begin
         hit_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else if (cmp_en) begin
         // lowest slot wins in both searches
         if (match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = cmp_idx;
         end
         if (!cmp_slot_valid && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = cmp_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff  <= hit_idx_in;
      free_idx_ff <= free_idx_in;
      if (reset) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
   end

   assign flags.hit_found  = hit_found_ff;
   assign flags.free_found = free_found_ff;
   assign hit_idx          = hit_idx_ff;
   assign free_idx         = free_idx_ff;

endmodule

FILE: sv/string_set_table.sv
// string set table: a shared table of SLOTS fixed-length keys, each tagged
// with one of NUM_SETS sets, with a member count per set.
// req channel: one beat carries cmd (add or remove), set_sel and the key in
// four words; bytes at or beyond KEY_BYTES are ignored.
// rsp channel: one beat per request with status and the set's count after
// the command.
// the sequencer walks every slot through one compare unit, one slot per
// cycle, reading set tag and key from the slot memory (registered read).
// a command runs through the scan over the slot memory, then updates the
// table, presents the response beat and goes back to idle before req.ready
// rises again.
// a set at or beyond NUM_SETS skips the scan and answers in the cycle after it is accepted.
// req.ready is high only while no command is in progress and reset is low;
// a stalled rsp beat holds its payload and keeps the block from taking the
// next request.
// reset clears the slot valid bits, the set counts and the sequencer; key
// storage is not cleared, as only valid slots can ever match.
// depends on sst_pkg, sst_if, sst_slot_mem and sst_scan
module string_set_table import sst_pkg::*; #(
   parameter int SLOTS     = SST_SLOTS,
   parameter int NUM_SETS  = SST_NUM_SETS,
   parameter int KEY_BYTES = SST_KEY_BYTES
) (
   input logic      clock,
   input logic      reset,
   sst_req_if.sink  req,
   sst_rsp_if.source rsp
);

   localparam int AW     = $clog2(SLOTS);
   localparam int SCAN_W = $clog2(SLOTS + 1);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int SET_IW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   logic [SCAN_W-1:0]    scan_ff, scan_in;
   logic                 cmp_en_ff, cmp_en_in;
   logic [AW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 cmd_ff, cmd_in;
   logic [SET_W-1:0]     set_ff, set_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0]     count_ff [NUM_SETS];
   logic [CNT_W-1:0]     count_in [NUM_SETS];
   logic [SLOTS-1:0]     valid_ff, valid_in;

   logic [KEY_W-1:0]     key_mask;
   logic [KEY_W-1:0]     key_masked;
   logic                 set_out_of_range;
   logic [SET_IW-1:0]    set_idx;
   logic [CNT_W-1:0]     cur_count;
   logic                 scan_start;
   logic                 mem_wr;
   logic [ENTRY_W-1:0]   rd_entry;
   scan_flags_type       flags;
   logic [AW-1:0]        hit_idx;
   logic [AW-1:0]        free_idx;

   // bytes past KEY_BYTES take no part in storing or comparing
   always_comb begin
      for (int i = 0; i < KEY_W; i++) begin
         key_mask[i] = (i < KEY_BYTES * 8);
      end
   end

   assign key_masked = {req.key_w3, req.key_w2, req.key_w1, req.key_w0} & key_mask;
   assign set_out_of_range = (int'(req.set_sel) >= NUM_SETS);
   assign set_idx   = SET_IW'(set_ff);
   assign cur_count = count_ff[set_idx];

   sst_slot_mem #(.SLOTS(SLOTS)) u_slot_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (free_idx),
      .wr_data ({set_ff, key_ff}),
      .rd_addr (scan_ff[AW-1:0]),
      .rd_data (rd_entry)
   );

   sst_scan #(.SLOTS(SLOTS)) u_scan (
      .clock          (clock),
      .reset          (reset),
      .start          (scan_start),
      .cmp_en         (cmp_en_ff),
      .cmp_idx        (cmp_idx_ff),
      .cmp_slot_valid (valid_ff[cmp_idx_ff]),
      .cmp_entry      (rd_entry),
      .key            (key_ff),
      .set_sel        (set_ff),
      .flags          (flags),
      .hit_idx        (hit_idx),
      .free_idx       (free_idx)
   );

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      cmp_en_in     = 1'b0;
      cmp_idx_in    = scan_ff[AW-1:0];
      cmd_in        = cmd_ff;
      set_in        = set_ff;
      key_in        = key_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      count_in      = count_ff;
      valid_in      = valid_ff;
      scan_start    = 1'b0;
      mem_wr        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               cmd_in     = req.cmd;
               set_in     = req.set_sel;
               key_in     = key_masked;
               scan_in    = '0;
               scan_start = 1'b1;
               if (set_out_of_range) begin
                  rsp_status_in = ST_NOT_FOUND;
                  rsp_count_in  = '0;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // read slot n while the compare unit sees slot n-1
            if (scan_ff == SCAN_W'(SLOTS)) begin
               state_in = S_COMMIT;
            end else begin
               cmp_en_in = 1'b1;
               scan_in   = scan_ff + 1'b1;
            end
         end
         S_COMMIT: begin
            if (cmd_ff == CMD_ADD) begin
               if (flags.hit_found) begin
                  rsp_status_in = ST_PRESENT;
               end else if (!flags.free_found) begin
                  rsp_status_in = ST_FULL;
               end else begin
                  mem_wr             = 1'b1;
                  valid_in[free_idx] = 1'b1;
                  count_in[set_idx]  = cur_count + 1'b1;
                  rsp_status_in      = ST_ADDED;
               end
            end else begin
               if (flags.hit_found) begin
                  valid_in[hit_idx] = 1'b0;
                  if (cur_count != '0) begin
                     count_in[set_idx] = cur_count - 1'b1;
                  end
                  rsp_status_in = ST_REMOVED;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end
            rsp_count_in = COUNT_W'(count_in[set_idx]);
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      cmd_ff        <= cmd_in;
      set_ff        <= set_in;
      key_ff        <= key_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      if (reset) begin
         state_ff  <= S_IDLE;
         cmp_en_ff <= 1'b0;
         valid_ff  <= '0;
         for (int s = 0; s < NUM_SETS; s++) begin
            count_ff[s] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         cmp_en_ff <= cmp_en_in;
         valid_ff  <= valid_in;
         count_ff  <= count_in;
      end
   end

   // no beat is taken while reset holds the sequencer
   assign req.ready     = (state_ff == S_IDLE) && !reset;
   assign rsp.valid     = (state_ff == S_RESP);
   assign rsp.status    = rsp_status_ff;
   assign rsp.set_count = rsp_count_ff;

endmodule
